### hdl/jbps_pkg.sv
// ----------------------------------------------------------------------------
// jbps_pkg
// Types, codes and constants shared by the bit packer with byte stuffing.
// ----------------------------------------------------------------------------
package jbps_pkg;

  localparam int CODE_W        = 32;
  localparam int LEN_W         = 6;
  localparam int BYTE_W        = 8;
  localparam int PEND_W        = 7;
  localparam int MAX_CODE_BITS_DEF = 32;
  localparam int QUEUE_DEPTH   = 4;
  localparam int PADDR_W       = 3;
  localparam int PDATA_W       = 32;

  localparam logic [BYTE_W-1:0] MARKER_BYTE = 8'hFF;
  localparam logic [BYTE_W-1:0] STUFF_BYTE  = 8'h00;

  // register indexes
  localparam logic REG_PAD_WITH_ONES = 1'b0;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_FLUSH  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_STUFF
  } state_t;

  typedef struct packed {
    logic              command;
    logic [CODE_W-1:0] code_value;
    logic [LEN_W-1:0]  code_length;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
  } out_item_t;

  typedef struct packed {
    op_t               op;
    logic [CODE_W-1:0] code_value;
    logic [LEN_W-1:0]  code_length;
  } q_entry_t;

endpackage

### hdl/jbps_front.sv
// ----------------------------------------------------------------------------
// jbps_front
// Input stage: classifies items, saturates the code length, masks the value
// and drops appends of zero length before they reach the queue.
// ----------------------------------------------------------------------------
module jbps_front import jbps_pkg::*; #(
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     full,
  output logic     wr_en,
  output q_entry_t wr_entry
);

  localparam int LEN_CAP = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;

  logic [LEN_W-1:0]  len_sat;
  logic [CODE_W-1:0] val_mask;
  op_t               op;

  always_comb begin
    op = op_t'(in_data.command);
    if (in_data.code_length > LEN_W'(LEN_CAP)) begin
      len_sat = LEN_W'(LEN_CAP);
    end else begin
      len_sat = in_data.code_length;
    end
    val_mask = ~({CODE_W{1'b1}} << len_sat);
  end

  assign in_ready = !full;

  always_comb begin
    wr_entry.op          = op;
    wr_entry.code_value  = in_data.code_value & val_mask;
    wr_entry.code_length = len_sat;
    // zero length appends change nothing
    wr_en = in_valid && in_ready && ((op == OP_FLUSH) || (len_sat != '0));
  end

endmodule

### hdl/jbps_fifo.sv
// ----------------------------------------------------------------------------
// jbps_fifo
// Short queue of classified items between the front and back stages.
// ----------------------------------------------------------------------------
module jbps_fifo import jbps_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_en,
  input  q_entry_t wr_entry,
  input  logic     rd_en,
  output q_entry_t rd_entry,
  output logic     full,
  output logic     empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  q_entry_t         slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hdl/jbps_back.sv
// ----------------------------------------------------------------------------
// jbps_back
// Packing stage: merges queued codes into the bit accumulator and emits one
// byte per cycle into the output register while the output is not stalled, inserting a zero after each 0xFF.
// ----------------------------------------------------------------------------
module jbps_back import jbps_pkg::*; #(
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      pad_with_ones,
  input  logic      empty,
  input  q_entry_t  rd_entry,
  output logic      rd_en,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int LEN_CAP = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;
  localparam int ACC_W   = LEN_CAP + PEND_W;
  localparam int CNT_W   = $clog2(ACC_W + 1);

  state_t           state;
  state_t           state_next;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] acc_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             load_out;
  out_item_t        out_next;

  logic              slot_free;
  logic [CNT_W-1:0]  cnt_less8;
  logic [BYTE_W-1:0] cur_byte;
  logic [PEND_W-1:0] kept;
  logic [3:0]        gap;
  logic [BYTE_W-1:0] pad_bits;
  logic              do_merge;
  logic [LEN_W-1:0]  merge_len;
  logic [ACC_W-1:0]  merge_val;

  assign slot_free = !out_valid || out_ready;
  assign cnt_less8 = cnt - CNT_W'(BYTE_W);
  assign cur_byte  = BYTE_W'(acc >> cnt_less8);
  assign kept      = acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << cnt[2:0]);
  assign gap       = 4'(BYTE_W) - {1'b0, cnt[2:0]};
  assign pad_bits  = pad_with_ones ? ~({BYTE_W{1'b1}} << gap) : '0;

  // merge selection
  always_comb begin
    do_merge  = 1'b0;
    merge_len = '0;
    merge_val = '0;
    if (rd_entry.op == OP_FLUSH) begin
      if (cnt[2:0] != 3'd0) begin
        do_merge  = 1'b1;
        merge_len = LEN_W'(gap);
        merge_val = ACC_W'(pad_bits);
      end
    end else begin
      do_merge  = 1'b1;
      merge_len = rd_entry.code_length;
      merge_val = ACC_W'(rd_entry.code_value);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!empty && do_merge &&
            ({1'b0, cnt} + (CNT_W+1)'(merge_len) >= (CNT_W+1)'(BYTE_W))) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          if (cur_byte == MARKER_BYTE) begin
            state_next = ST_STUFF;
          end else if (cnt_less8 < CNT_W'(BYTE_W)) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_STUFF: begin
        if (slot_free) begin
          state_next = (cnt < CNT_W'(BYTE_W)) ? ST_IDLE : ST_EMIT;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    rd_en    = 1'b0;
    load_out = 1'b0;
    out_next = out_data;
    acc_next = acc;
    cnt_next = cnt;
    case (state)
      ST_IDLE: begin
        if (!empty) begin
          rd_en = 1'b1;
          if (do_merge) begin
            acc_next = (ACC_W'(kept) << merge_len) | merge_val;
            cnt_next = CNT_W'({1'b0, cnt[2:0]}) + CNT_W'(merge_len);
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          load_out          = 1'b1;
          out_next.out_byte = cur_byte;
          out_next.last     = (cnt_less8 < CNT_W'(BYTE_W)) && (cur_byte != MARKER_BYTE);
          cnt_next          = cnt_less8;
        end
      end
      ST_STUFF: begin
        if (slot_free) begin
          load_out          = 1'b1;
          out_next.out_byte = STUFF_BYTE;
          out_next.last     = (cnt < CNT_W'(BYTE_W));
        end
      end
      default: begin
        cnt_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
    if (load_out) begin
      out_data <= out_next;
    end
  end

endmodule

### hdl/jpeg_bit_packer_stuffing.sv
// ----------------------------------------------------------------------------
// jpeg_bit_packer_stuffing
// Entropy-coded stream writer: packs variable-length codes MSB first into
// bytes, inserts a zero after every 0xFF and pads the partial byte on flush.
//
//   channel   dir   handshake                 payload
//   in        in    in_valid / in_ready       in_data (command, code, length)
//   out       out   out_valid / out_ready     out_data (out_byte, last)
//   cfg       in    psel penable pwrite       paddr, pwdata, prdata
//
// an item leaves the queue through the idle state of the packing stage, then
// each byte and each stuffed zero is emitted from the emit and stuff states
// an item with no byte passes only the idle state, a zero length append never reaches the queue
// the four-entry queue lets the input side run ahead while the output stalls
// rst is synchronous and clears the partial byte, the queue and the output
// ----------------------------------------------------------------------------
module jpeg_bit_packer_stuffing import jbps_pkg::*; #(
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic     pad_with_ones;
  logic     full;
  logic     empty;
  logic     wr_en;
  logic     rd_en;
  q_entry_t wr_entry;
  q_entry_t rd_entry;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_with_ones <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[PADDR_W-1] == REG_PAD_WITH_ONES)) begin
      pad_with_ones <= pwdata[0];
    end
  end

  assign prdata = (paddr[PADDR_W-1] == REG_PAD_WITH_ONES) ?
                  PDATA_W'(pad_with_ones) : '0;

  jbps_front #(
    .MAX_CODE_BITS(MAX_CODE_BITS)
  ) u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .full     (full),
    .wr_en    (wr_en),
    .wr_entry (wr_entry)
  );

  jbps_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_entry (rd_entry),
    .full     (full),
    .empty    (empty)
  );

  jbps_back #(
    .MAX_CODE_BITS(MAX_CODE_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .pad_with_ones (pad_with_ones),
    .empty         (empty),
    .rd_entry      (rd_entry),
    .rd_en         (rd_en),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data)
  );

endmodule

### hdl/jbps_checker.sv
// ----------------------------------------------------------------------------
// jbps_checker
// Port-level checks for the bit packer, bound to the top level.
// ----------------------------------------------------------------------------
module jbps_checker import jbps_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input out_item_t          out_data
);

  // stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  // a marker byte is never the final byte of an item
  a_ff_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.out_byte == MARKER_BYTE) |-> !out_data.last)
    else $error("0xFF marked last");

  // the byte after an accepted 0xFF is the stuffed zero
  a_stuff_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && (out_data.out_byte == MARKER_BYTE) |=>
    !out_valid || (out_data.out_byte == STUFF_BYTE))
    else $error("missing stuffed zero");

  // reset empties the output register
  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind jpeg_bit_packer_stuffing jbps_checker u_checker (.*);

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the JPEG bit packer with byte stuffing. Appends and
// flushes go in through a randomly paced driver. A local bit packer predicts
// every stream byte, each stuffed zero after 0xFF and the last flag. A
// monitor with random and long back-pressure compares the output with the
// predicted bytes in order. The padding register is rewritten between phases
// while the block is drained.
// ----------------------------------------------------------------------------
module tb_top;
  import jbps_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_WAIT = 16;
  localparam int LONG_HOLD  = 250;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid = 1'b0;
  logic               in_ready;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // pending codes and predicted stream
  in_item_t    code_q[$];
  out_item_t   stream_q[$];
  out_item_t   burst_q[$];

  // packer state as predicted
  logic [PEND_W-1:0] pend_bits = '0;
  logic [2:0]        pend_cnt = '0;
  logic              pad_ones = 1'b0;

  int unsigned err_cnt = 0;
  int unsigned idle_cyc = 0;
  int unsigned send_gap = 0;
  int unsigned sent_cnt = 0;
  int unsigned res_cnt = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  out_item_t   want;

  jpeg_bit_packer_stuffing i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (err_cnt < 20) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
    err_cnt++;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // stretches without any idling
  function automatic bit calm(input int unsigned n);
    return (n % 96) < 24;
  endfunction

  function automatic in_item_t make_item(input op_t op, input logic [CODE_W-1:0] v,
                                         input logic [LEN_W-1:0] l);
    in_item_t it;
    it.command     = op;
    it.code_value  = v;
    it.code_length = l;
    return it;
  endfunction

  function automatic in_item_t rand_item();
    int unsigned r;
    logic [CODE_W-1:0] v;
    logic [LEN_W-1:0] l;
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0, 1:    v = 32'hFFFF_FFFF;
      2:       v = '0;
      default: v = $urandom;
    endcase
    if (r < 12) return make_item(OP_FLUSH, v, LEN_W'($urandom));
    if (r < 16) l = '0;
    else if (r < 22) l = LEN_W'($urandom_range(33, 63));
    else if (r < 50) l = LEN_W'($urandom_range(1, 8));
    else if (r < 85) l = LEN_W'($urandom_range(9, 16));
    else l = LEN_W'($urandom_range(17, 32));
    return make_item(OP_APPEND, v, l);
  endfunction

  task automatic add_byte(input logic [BYTE_W-1:0] b);
    burst_q.push_back(out_item_t'{out_byte: b, last: 1'b0});
    if (b == MARKER_BYTE) begin
      burst_q.push_back(out_item_t'{out_byte: STUFF_BYTE, last: 1'b0});
    end
  endtask

  // bytes that one code or flush adds to the stream
  task automatic pack_item(input in_item_t it);
    logic [63:0] acc;
    int unsigned cnt;
    int unsigned len;
    logic [BYTE_W-1:0] b;
    out_item_t tail;
    burst_q.delete();
    if (it.command == OP_FLUSH) begin
      if (pend_cnt != 0) begin
        b = {1'b0, pend_bits} << (8 - pend_cnt);
        if (pad_ones) b = b | (8'hFF >> pend_cnt);
        add_byte(b);
        pend_bits = '0;
        pend_cnt = '0;
      end
    end else begin
      len = it.code_length;
      if (len > 32) len = 32;
      if (len > MAX_CODE_BITS_DEF) len = MAX_CODE_BITS_DEF;
      if (len != 0) begin
        acc = ({57'd0, pend_bits} << len) | (64'(it.code_value) & ((64'd1 << len) - 64'd1));
        cnt = pend_cnt + len;
        while (cnt >= 8) begin
          cnt -= 8;
          add_byte(BYTE_W'(acc >> cnt));
        end
        pend_bits = PEND_W'(acc & ((64'd1 << cnt) - 64'd1));
        pend_cnt = 3'(cnt);
      end
    end
    if (burst_q.size() != 0) begin
      tail = burst_q.pop_back();
      tail.last = 1'b1;
      burst_q.push_back(tail);
      foreach (burst_q[k]) stream_q.push_back(burst_q[k]);
    end
  endtask

  task automatic write_pad(input logic v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({REG_PAD_WITH_ONES, 2'b00});
    pwdata  <= PDATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pad_ones = v;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (code_q.size() != 0 || in_valid || stream_q.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic queue_random(input int n);
    @(negedge clk);
    repeat (n) code_q.push_back(rand_item());
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        pack_item(in_data);
        sent_cnt++;
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (code_q.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= code_q.pop_front();
        send_gap = calm(sent_cnt) ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        res_cnt++;
        if (stream_q.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h", out_data.out_byte));
        end else begin
          want = stream_q.pop_front();
          if (out_data.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, predicted %02h",
                                      out_data.out_byte, want.out_byte));
          if (out_data.last !== want.last)
            report_mismatch($sformatf("last %b, predicted %b on byte %02h",
                                      out_data.last, want.last, want.out_byte));
        end
      end
      if (!hold_done && res_cnt >= 40) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left = calm(res_cnt) ? 0 : pick_gap();
      end
    end
  end

  // watchdog on transaction progress
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // zero padding, directed
    write_pad(1'b0);
    @(negedge clk);
    code_q.push_back(make_item(OP_APPEND, 32'hFFFF_FFFF, 6'd0));
    code_q.push_back(make_item(OP_FLUSH, 32'hDEAD_BEEF, 6'd63));
    code_q.push_back(make_item(OP_APPEND, 32'h0000_00FF, 6'd8));
    code_q.push_back(make_item(OP_APPEND, 32'hFFFF_FFFF, 6'd32));
    code_q.push_back(make_item(OP_APPEND, 32'h0000_0000, 6'd32));
    code_q.push_back(make_item(OP_APPEND, 32'hA5A5_A5A5, 6'd63));
    code_q.push_back(make_item(OP_APPEND, 32'hFFFF_0000, 6'd40));
    code_q.push_back(make_item(OP_APPEND, 32'hFFFF_FFFD, 6'd3));
    code_q.push_back(make_item(OP_FLUSH, 32'h0000_0000, 6'd0));
    code_q.push_back(make_item(OP_APPEND, 32'h0000_001F, 6'd5));
    code_q.push_back(make_item(OP_APPEND, 32'hFFFF_FFFF, 6'd3));
    code_q.push_back(make_item(OP_APPEND, 32'h0000_0001, 6'd1));
    code_q.push_back(make_item(OP_FLUSH, 32'hFFFF_FFFF, 6'd32));
    code_q.push_back(make_item(OP_APPEND, 32'hFFFF_FF80, 6'd7));
    code_q.push_back(make_item(OP_APPEND, 32'h1234_5678, 6'd0));
    code_q.push_back(make_item(OP_FLUSH, 32'h5555_5555, 6'd21));
    wait_drained();

    // ones padding, directed then random
    write_pad(1'b1);
    @(negedge clk);
    code_q.push_back(make_item(OP_APPEND, 32'h0000_007F, 6'd7));
    code_q.push_back(make_item(OP_FLUSH, 32'h0000_0000, 6'd0));
    code_q.push_back(make_item(OP_APPEND, 32'hFFFF_FFFE, 6'd1));
    code_q.push_back(make_item(OP_FLUSH, 32'hAAAA_AAAA, 6'd42));
    code_q.push_back(make_item(OP_FLUSH, 32'h0000_0000, 6'd0));
    code_q.push_back(make_item(OP_APPEND, 32'h0000_000A, 6'd4));
    code_q.push_back(make_item(OP_FLUSH, 32'h0000_0000, 6'd0));
    queue_random(70);
    wait_drained();

    write_pad(1'b0);
    queue_random(60);
    wait_drained();

    write_pad(1'b1);
    queue_random(60);
    wait_drained();

    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/jbps_pkg.sv
hdl/jbps_front.sv
hdl/jbps_fifo.sv
hdl/jbps_back.sv
hdl/jpeg_bit_packer_stuffing.sv
hdl/jbps_checker.sv
tb/tb_top.sv
